// ----- sv/current_load_pi_regulator_assert.svh -----
// assertion macros for the current load pi regulator
`ifndef CURRENT_LOAD_PI_REGULATOR_ASSERT_SVH
`define CURRENT_LOAD_PI_REGULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CLPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clpi assertion failed");
// next-cycle implication
`define CLPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clpi assertion failed");
`else
`define CLPI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CLPI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/clpi_pkg.sv -----
// shared types, constants and conversion tables for the current load pi regulator
package clpi_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 8;
  localparam int LEVELS     = 1 << SAMPLE_W;
  localparam int VOLT_W     = 24;
  localparam int SETP_W     = 20;
  localparam int CURR_W     = 20;
  localparam int POWER_W    = 27;
  localparam int DUTY_W     = 16;
  localparam int GAIN_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int MINSP_W    = 16;

  // internal arithmetic widths
  localparam int ERR_W      = SETP_W + 1;
  localparam int SUM_W      = 40;
  localparam int PROD_W     = VOLT_W + CURR_W;
  localparam int PT_W       = ERR_W + GAIN_W + 1;
  localparam int IT_W       = SUM_W + GAIN_W + 1;
  localparam int DRV_W      = IT_W + 1;
  localparam int CAPQ_W     = GAIN_W + FRAC_BITS;
  localparam int SCALE_W    = CAPQ_W + PERIOD_W;
  localparam int DIV_NUM_W  = SCALE_W - FRAC_BITS;

  // radix-16 restoring divider
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = DIV_NUM_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_INT_CAP    = 3'd2,
    REG_DRIVE_CAP  = 3'd3,
    REG_PWM_PERIOD = 3'd4,
    REG_MIN_SETP   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   int_cap;
    logic [GAIN_W-1:0]   drive_cap;
    logic [PERIOD_W-1:0] pwm_period;
    logic [MINSP_W-1:0]  min_setp;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic conv;
    logic integ;
    logic gain;
    logic clamp;
    logic scale;
    logic div_step;
    logic push;
  } dp_cmd_t;

  // sample to value conversion constants
  localparam longint VOLT_MUL = 1584;
  localparam longint VOLT_DEN = 2550;
  localparam longint SETP_MUL = 10;
  localparam longint SETP_DEN = 255;
  localparam longint CURR_MUL = 3300;
  localparam longint CURR_DEN = 85680;
  localparam longint ONE_Q    = longint'(1) << FRAC_BITS;

  typedef logic [LEVELS-1:0][VOLT_W-1:0] volt_tab_t;
  typedef logic [LEVELS-1:0][SETP_W-1:0] setp_tab_t;
  typedef logic [LEVELS-1:0][CURR_W-1:0] curr_tab_t;

  // volts: round(s * 158.4 / 255)
  function automatic volt_tab_t build_volt_tab();
    volt_tab_t t;
    longint    n;
    for (int i = 0; i < LEVELS; i++) begin
      n    = longint'(i) * VOLT_MUL * ONE_Q;
      t[i] = VOLT_W'((n + VOLT_DEN / 2) / VOLT_DEN);
    end
    return t;
  endfunction

  // setpoint amps: round((255 - s) * 10 / 255), knob has inverted sense
  function automatic setp_tab_t build_setp_tab();
    setp_tab_t t;
    longint    n;
    for (int i = 0; i < LEVELS; i++) begin
      n    = longint'(LEVELS - 1 - i) * SETP_MUL * ONE_Q;
      t[i] = SETP_W'((n + SETP_DEN / 2) / SETP_DEN);
    end
    return t;
  endfunction

  // shunt amps: round(s * 3300 / 85680)
  function automatic curr_tab_t build_curr_tab();
    curr_tab_t t;
    longint    n;
    for (int i = 0; i < LEVELS; i++) begin
      n    = longint'(i) * CURR_MUL * ONE_Q;
      t[i] = CURR_W'((n + CURR_DEN / 2) / CURR_DEN);
    end
    return t;
  endfunction

  localparam volt_tab_t VOLT_TAB = build_volt_tab();
  localparam setp_tab_t SETP_TAB = build_setp_tab();
  localparam curr_tab_t CURR_TAB = build_curr_tab();

endpackage

// ----- sv/clpi_ifs.sv -----
// channel interfaces for samples, results and register writes
interface clpi_in_if;
  import clpi_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] voltage_sample;
  logic [SAMPLE_W-1:0] setpoint_sample;
  logic [SAMPLE_W-1:0] current_sample;
  modport source (output valid, voltage_sample, setpoint_sample, current_sample, input ready);
  modport sink (input valid, voltage_sample, setpoint_sample, current_sample, output ready);
endinterface

interface clpi_out_if;
  import clpi_pkg::*;
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_match;
  logic [VOLT_W-1:0]  voltage_value;
  logic [SETP_W-1:0]  setpoint_value;
  logic [CURR_W-1:0]  current_value;
  logic [POWER_W-1:0] power_value;
  modport source (output valid, duty_match, voltage_value, setpoint_value, current_value,
                  power_value, input ready);
  modport sink (input valid, duty_match, voltage_value, setpoint_value, current_value,
                power_value, output ready);
endinterface

interface clpi_cfg_if;
  import clpi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/current_load_pi_regulator.sv -----
// top level of the current load pi regulator
//
//   channel   role  payload
//   samples   sink  voltage_sample, setpoint_sample, current_sample
//   results   src   duty_match, voltage_value, setpoint_value, current_value, power_value
//   cfg       sink  index, data (always ready)
//
// items are taken one at a time: 5 sequenced arithmetic steps, 6 radix-16 divider
// iterations for the pwm match count, a step to load the result register, one idle step.
// the result register lets the next item be taken while a result waits.
// a stalled result holds the block in its final step until the transfer.
// synchronous reset clears the sequencer and the integral and sets the configuration registers to defaults.
`include "current_load_pi_regulator_assert.svh"

module current_load_pi_regulator (
  input  logic       clk,
  input  logic       rst,
  clpi_in_if.sink    samples,
  clpi_out_if.source results,
  clpi_cfg_if.sink   cfg
);
  import clpi_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;

  // configuration registers
  clpi_cfg_regs u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (cfg),
    .cfg (cfg_q)
  );

  // sequencer
  clpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  // arithmetic
  clpi_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg_q),
    .voltage_sample  (samples.voltage_sample),
    .setpoint_sample (samples.setpoint_sample),
    .current_sample  (samples.current_sample),
    .duty_match      (results.duty_match),
    .voltage_value   (results.voltage_value),
    .setpoint_value  (results.setpoint_value),
    .current_value   (results.current_value),
    .power_value     (results.power_value)
  );

  // checks
  `CLPI_ASSERT_NEXT(a_accept_busy, clk, rst, samples.valid && samples.ready, !samples.ready)
  `CLPI_ASSERT_IMPL(a_duty_in_period, clk, rst, results.valid, results.duty_match <= cfg_q.pwm_period)
  `CLPI_ASSERT_IMPL(a_zero_cap_duty, clk, rst, results.valid && cfg_q.drive_cap == 8'd0, results.duty_match == 16'd0)
  `CLPI_ASSERT_IMPL(a_setpoint_range, clk, rst, results.valid, results.setpoint_value <= 20'd655360)
endmodule

// ----- sv/clpi_cfg_regs.sv -----
// configuration register file
module clpi_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  clpi_cfg_if.sink        wr,
  output clpi_pkg::cfg_t  cfg
);
  import clpi_pkg::*;

  // always ready, one write per transfer
  assign wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p     <= GAIN_W'(20);
      cfg.gain_i     <= GAIN_W'(1);
      cfg.int_cap    <= GAIN_W'(255);
      cfg.drive_cap  <= GAIN_W'(255);
      cfg.pwm_period <= PERIOD_W'(1200);
      cfg.min_setp   <= MINSP_W'(655);
    end else if (wr.valid) begin
      case (cfg_reg_t'(wr.index))
        REG_GAIN_P:     cfg.gain_p     <= wr.data[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_i     <= wr.data[GAIN_W-1:0];
        REG_INT_CAP:    cfg.int_cap    <= wr.data[GAIN_W-1:0];
        REG_DRIVE_CAP:  cfg.drive_cap  <= wr.data[GAIN_W-1:0];
        REG_PWM_PERIOD: cfg.pwm_period <= wr.data[PERIOD_W-1:0];
        REG_MIN_SETP:   cfg.min_setp   <= wr.data[MINSP_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/clpi_ctrl.sv -----
// sequencing state machine and result valid flag
module clpi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output clpi_pkg::dp_cmd_t  cmd
);
  import clpi_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CONV  = 8'b0000_0010,
    ST_INTEG = 8'b0000_0100,
    ST_GAIN  = 8'b0000_1000,
    ST_CLAMP = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv   = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale    = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result valid: set on push, cleared by transfer
  assign out_valid_next = cmd.push || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

// ----- sv/clpi_datapath.sv -----
// conversion, pi step, clamp, pwm scaling and divider datapath
module clpi_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  clpi_pkg::dp_cmd_t             cmd,
  input  clpi_pkg::cfg_t                cfg,
  input  logic [clpi_pkg::SAMPLE_W-1:0] voltage_sample,
  input  logic [clpi_pkg::SAMPLE_W-1:0] setpoint_sample,
  input  logic [clpi_pkg::SAMPLE_W-1:0] current_sample,
  output logic [clpi_pkg::DUTY_W-1:0]   duty_match,
  output logic [clpi_pkg::VOLT_W-1:0]   voltage_value,
  output logic [clpi_pkg::SETP_W-1:0]   setpoint_value,
  output logic [clpi_pkg::CURR_W-1:0]   current_value,
  output logic [clpi_pkg::POWER_W-1:0]  power_value
);
  import clpi_pkg::*;

  localparam logic signed [SUM_W:0] SUM_FLOOR = {2'b11, {(SUM_W-1){1'b0}}};
  localparam logic [PROD_W:0]       HALF_LSB  = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic [VOLT_W-1:0]         volt;
  logic [SETP_W-1:0]         setp;
  logic [CURR_W-1:0]         curr;
  logic [PROD_W-1:0]         pow_prod;
  logic [POWER_W-1:0]        power;
  logic signed [ERR_W-1:0]   err;
  logic                      sp_off;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [PT_W-1:0]    p_term;
  logic signed [IT_W-1:0]    i_term;
  logic [CAPQ_W-1:0]         inv;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [GAIN_W-1:0]         div_rem;

  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W:0]     cap_wide;
  logic signed [SUM_W-1:0]   sum_next;
  logic [PROD_W:0]           pow_round;
  logic signed [DRV_W-1:0]   drive_wide;
  logic signed [DRV_W-1:0]   dmax_wide;
  logic [CAPQ_W-1:0]         dmax;
  logic [CAPQ_W-1:0]         drive;
  logic [SCALE_W-1:0]        scale_prod;
  logic [GAIN_W:0]           r;
  logic [DIV_NUM_W-1:0]      n;

  // integral update with cap above and register floor below
  assign sum_wide = {error_sum[SUM_W-1], error_sum} + (SUM_W+1)'(err);
  assign cap_wide = $signed({{(SUM_W+1-CAPQ_W){1'b0}}, cfg.int_cap, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (sum_wide > cap_wide) begin
      sum_next = cap_wide[SUM_W-1:0];
    end else if (sum_wide < SUM_FLOOR) begin
      sum_next = SUM_FLOOR[SUM_W-1:0];
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  // power rounding
  assign pow_round = {1'b0, pow_prod} + HALF_LSB;

  // drive sum and clamp to [0, drive_cap], forced to zero when the setpoint is below min_setp
  assign dmax       = {cfg.drive_cap, {FRAC_BITS{1'b0}}};
  assign dmax_wide  = $signed({{(DRV_W-CAPQ_W){1'b0}}, dmax});
  assign drive_wide = DRV_W'(p_term) + DRV_W'(i_term);

  always_comb begin
    if (sp_off || drive_wide < 0) begin
      drive = '0;
    end else if (drive_wide > dmax_wide) begin
      drive = dmax;
    end else begin
      drive = drive_wide[CAPQ_W-1:0];
    end
  end

  // inverted drive times period
  assign scale_prod = SCALE_W'(inv) * SCALE_W'(cfg.pwm_period);

  // four restoring divide steps per cycle, quotient shifts in at the bottom
  always_comb begin
    r = {1'b0, div_rem};
    n = div_num;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {r[GAIN_W-1:0], n[DIV_NUM_W-1]};
      n = {n[DIV_NUM_W-2:0], 1'b0};
      if (r >= {1'b0, cfg.drive_cap}) begin
        r    = r - {1'b0, cfg.drive_cap};
        n[0] = 1'b1;
      end
    end
  end

  // integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (cmd.integ) begin
      error_sum <= sum_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt <= VOLT_TAB[voltage_sample];
      setp <= SETP_TAB[setpoint_sample];
      curr <= CURR_TAB[current_sample];
    end
    if (cmd.conv) begin
      pow_prod <= PROD_W'(volt) * PROD_W'(curr);
      err      <= $signed({1'b0, setp}) - $signed({1'b0, curr});
      sp_off   <= setp < SETP_W'(cfg.min_setp);
    end
    if (cmd.integ) begin
      p_term <= $signed({1'b0, cfg.gain_p}) * err;
      power  <= pow_round[FRAC_BITS +: POWER_W];
    end
    if (cmd.gain) begin
      i_term <= $signed({1'b0, cfg.gain_i}) * error_sum;
    end
    if (cmd.clamp) begin
      inv <= dmax - drive;
    end
    if (cmd.scale) begin
      div_num <= scale_prod[SCALE_W-1 -: DIV_NUM_W];
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_num <= n;
      div_rem <= r[GAIN_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      duty_match     <= (cfg.drive_cap == '0) ? '0 : div_num[DUTY_W-1:0];
      voltage_value  <= volt;
      setpoint_value <= setp;
      current_value  <= curr;
      power_value    <= power;
    end
  end
endmodule

// ----- tb/current_load_pi_regulator_checker.sv -----
// checker for the current load pi regulator: mirrors registers and integral, predicts results
module current_load_pi_regulator_checker (
  input  logic       clk,
  input  logic       rst,
  clpi_in_if         samples,
  clpi_out_if        results,
  clpi_cfg_if        cfg,
  output int         outstanding,
  output int         failures
);
  import clpi_pkg::*;

  // conversion constants: volts = s * 1584 / 2550, amps = (255 - s) * 10 / 255, s * 3300 / 85680
  localparam longint VOLT_NUM   = 1584;
  localparam longint VOLT_DIV   = 2550;
  localparam longint KNOB_NUM   = 10;
  localparam longint KNOB_DIV   = 255;
  localparam longint SHUNT_NUM  = 3300;
  localparam longint SHUNT_DIV  = 85680;
  localparam longint KNOB_TOP   = 255;
  localparam longint INTEG_LOW  = -(longint'(1) <<< (SUM_W - 1));
  localparam longint INTEG_HIGH = (longint'(1) <<< (SUM_W - 1)) - 1;

  localparam cfg_t CFG_DEFAULTS = '{
    gain_p:     8'd20,
    gain_i:     8'd1,
    int_cap:    8'd255,
    drive_cap:  8'd255,
    pwm_period: 16'd1200,
    min_setp:   16'd655
  };

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [VOLT_W-1:0]  volts;
    logic [SETP_W-1:0]  setpoint;
    logic [CURR_W-1:0]  amps;
    logic [POWER_W-1:0] watts;
  } regulator_result_t;

  cfg_t              settings;
  longint            integral;
  regulator_result_t pending_results[$];
  regulator_result_t oldest;

  initial failures = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%s mismatch: got %0d, expected %0d", what, got, want);
    failures++;
  endtask

  // register write, value masked to the register width
  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_GAIN_P:     settings.gain_p     = data[GAIN_W-1:0];
      REG_GAIN_I:     settings.gain_i     = data[GAIN_W-1:0];
      REG_INT_CAP:    settings.int_cap    = data[GAIN_W-1:0];
      REG_DRIVE_CAP:  settings.drive_cap  = data[GAIN_W-1:0];
      REG_PWM_PERIOD: settings.pwm_period = data[PERIOD_W-1:0];
      REG_MIN_SETP:   settings.min_setp   = data[MINSP_W-1:0];
      default: ;
    endcase
  endtask

  // one regulator step: conversions, integral update, drive clamp, pwm match
  function automatic regulator_result_t regulate_sample(input logic [SAMPLE_W-1:0] vs,
                                                        input logic [SAMPLE_W-1:0] ss,
                                                        input logic [SAMPLE_W-1:0] cs);
    longint one, volts, setp, amps, watts, err, cap_q, drive, dmax, duty;
    regulator_result_t r;
    one   = longint'(1) <<< FRAC_BITS;
    volts = (longint'(vs) * VOLT_NUM * one + VOLT_DIV / 2) / VOLT_DIV;
    setp  = ((KNOB_TOP - longint'(ss)) * KNOB_NUM * one + KNOB_DIV / 2) / KNOB_DIV;
    amps  = (longint'(cs) * SHUNT_NUM * one + SHUNT_DIV / 2) / SHUNT_DIV;
    watts = (volts * amps + (one >>> 1)) >>> FRAC_BITS;

    // integral, capped above in whole units and at the register floor
    err      = setp - amps;
    cap_q    = longint'(settings.int_cap) * one;
    integral = integral + err;
    if (integral > cap_q) integral = cap_q;
    if (integral < INTEG_LOW) integral = INTEG_LOW;
    if (integral > INTEG_HIGH) integral = INTEG_HIGH;

    // drive clamp and small setpoint cutoff
    drive = longint'(settings.gain_p) * err + longint'(settings.gain_i) * integral;
    dmax  = longint'(settings.drive_cap) * one;
    if (drive > dmax) drive = dmax;
    if (drive < 0) drive = 0;
    if ((setp <<< 16) < (longint'(settings.min_setp) <<< FRAC_BITS)) drive = 0;

    // inverted drive scaled to the period, zero for a zero drive cap
    duty = 0;
    if (settings.drive_cap != 0) duty = ((dmax - drive) * longint'(settings.pwm_period)) / dmax;

    r.duty     = DUTY_W'(duty);
    r.volts    = VOLT_W'(volts);
    r.setpoint = SETP_W'(setp);
    r.amps     = CURR_W'(amps);
    r.watts    = POWER_W'(watts);
    return r;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      settings = CFG_DEFAULTS;
      integral = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) apply_register(cfg.index, cfg.data);

      // compare a result transfer with the oldest prediction
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, duty_match", results.duty_match, 0);
        end else begin
          oldest = pending_results.pop_front();
          if (results.duty_match !== oldest.duty)
            report_mismatch("duty_match", results.duty_match, oldest.duty);
          if (results.voltage_value !== oldest.volts)
            report_mismatch("voltage_value", results.voltage_value, oldest.volts);
          if (results.setpoint_value !== oldest.setpoint)
            report_mismatch("setpoint_value", results.setpoint_value, oldest.setpoint);
          if (results.current_value !== oldest.amps)
            report_mismatch("current_value", results.current_value, oldest.amps);
          if (results.power_value !== oldest.watts)
            report_mismatch("power_value", results.power_value, oldest.watts);
        end
      end

      if (samples.valid && samples.ready)
        pending_results.push_back(regulate_sample(samples.voltage_sample,
                                                  samples.setpoint_sample,
                                                  samples.current_sample));
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the current load pi regulator: clock, reset, stimulus and verdict
module testbench;
  import clpi_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 220;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   send_idle;
  int   recv_idle;
  logic hold_arm;
  logic hold_done;
  int   hold_left;
  int   outstanding;
  int   failures;

  clpi_in_if  sample_ch ();
  clpi_out_if result_ch ();
  clpi_cfg_if cfg_ch ();

  current_load_pi_regulator u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  current_load_pi_regulator_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .samples     (sample_ch),
    .results     (result_ch),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .failures    (failures)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      result_ch.ready <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // one sample transfer, with an optional gap before it
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] s,
                             input logic [SAMPLE_W-1:0] c);
    if ($urandom_range(99) < send_idle) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.voltage_sample  <= v;
    sample_ch.setpoint_sample <= s;
    sample_ch.current_sample  <= c;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // one register write transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering samples and wait for every predicted result
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // full register set; 8-bit registers get junk in the upper data bits
  task automatic apply_settings(input logic [7:0] gp, input logic [7:0] gi, input logic [7:0] ic,
                                input logic [7:0] dc, input logic [15:0] pp,
                                input logic [15:0] ms);
    drain();
    write_reg(REG_GAIN_P,     {8'($urandom), gp});
    write_reg(REG_GAIN_I,     {8'($urandom), gi});
    write_reg(REG_INT_CAP,    {8'($urandom), ic});
    write_reg(REG_DRIVE_CAP,  {8'($urandom), dc});
    write_reg(REG_PWM_PERIOD, pp);
    write_reg(REG_MIN_SETP,   ms);
    write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
  endtask

  function automatic logic [7:0] pick_byte(input int lo);
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'(lo);
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(lo, 255));
  endfunction

  function automatic logic [15:0] pick_word(input int lo, input int typical);
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'(lo);
    if (roll == 1) return 16'hFFFF;
    if (roll < 5) return 16'($urandom_range(lo, 65535));
    return 16'($urandom_range(lo, typical));
  endfunction

  // mostly bursts where the shunt current tracks a fixed knob, the rest free noise
  task automatic run_random(input int count);
    logic [SAMPLE_W-1:0] knob, v, s, c;
    int burst, track;
    burst = 0;
    knob  = '0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(5, 40);
        knob  = 8'($urandom_range(0, 255));
      end
      burst--;
      v = 8'($urandom_range(0, 255));
      if ($urandom_range(99) < 70) begin
        track = ((255 - int'(knob)) * 1019) / 1000 + int'($urandom_range(0, 8)) - 4;
        if (track < 0) track = 0;
        if (track > 255) track = 255;
        s = knob;
        c = 8'(track);
      end else begin
        s = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
      end
      send_sample(v, s, c);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst                       <= 1'b1;
    hold_arm                  <= 1'b0;
    sample_ch.valid           <= 1'b0;
    sample_ch.voltage_sample  <= '0;
    sample_ch.setpoint_sample <= '0;
    sample_ch.current_sample  <= '0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.index              <= '0;
    cfg_ch.data               <= '0;
    send_idle = 23;
    recv_idle <= 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: sample extremes, setpoint cutoff, drive clamp both ways
    send_sample(8'd0, 8'd0, 8'd0);
    send_sample(8'd255, 8'd255, 8'd255);
    send_sample(8'd0, 8'd255, 8'd0);
    repeat (3) send_sample(8'd255, 8'd0, 8'd0);
    send_sample(8'd0, 8'd0, 8'd255);
    send_sample(8'd128, 8'd128, 8'd128);
    send_sample(8'd170, 8'd85, 8'd85);
    send_sample(8'd85, 8'd170, 8'd200);
    send_sample(8'd1, 8'd254, 8'd1);
    send_sample(8'd254, 8'd1, 8'd254);

    // extreme gains, integral capped at zero, widest period, no cutoff
    apply_settings(8'd255, 8'd255, 8'd0, 8'd255, 16'hFFFF, 16'd0);
    send_sample(8'd255, 8'd0, 8'd0);
    repeat (2) send_sample(8'd0, 8'd0, 8'd255);
    send_sample(8'd90, 8'd20, 8'd250);

    // zero gains, smallest drive cap and period, highest cutoff
    apply_settings(8'd0, 8'd0, 8'd255, 8'd1, 16'd1, 16'hFFFF);
    send_sample(8'd200, 8'd0, 8'd0);
    send_sample(8'd30, 8'd200, 8'd10);

    // zero drive cap
    apply_settings(8'd20, 8'd1, 8'd255, 8'd0, 16'd1200, 16'd655);
    send_sample(8'd100, 8'd50, 8'd60);
    send_sample(8'd100, 8'd0, 8'd0);

    // zero period
    apply_settings(8'd20, 8'd1, 8'd255, 8'd100, 16'd0, 16'd655);
    send_sample(8'd100, 8'd50, 8'd60);
    send_sample(8'd40, 8'd10, 8'd30);

    // random settings and samples, idle profile moving through three stages
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle = 74;
        recv_idle <= 23;
      end else if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle = 0;
        recv_idle <= 0;
      end
      apply_settings(pick_byte(0), pick_byte(0), pick_byte(0), pick_byte(1),
                     pick_word(1, 4000), pick_word(0, 20000));
      if (p == 1) hold_arm <= 1'b1;
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- current_load_pi_regulator.f -----
+incdir+sv
sv/clpi_pkg.sv
sv/clpi_ifs.sv
sv/clpi_cfg_regs.sv
sv/clpi_ctrl.sv
sv/clpi_datapath.sv
sv/current_load_pi_regulator.sv
tb/current_load_pi_regulator_checker.sv
tb/testbench.sv
